// ===== hw/rtl/dgs_pkg.sv =====
// shared types and constants for the density grid splat block
package dgs_pkg;

  // operation codes
  localparam logic [1:0] FUNC_ADD   = 2'd0;
  localparam logic [1:0] FUNC_SUB   = 2'd1;
  localparam logic [1:0] FUNC_QUERY = 2'd2;

  // result status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_EDGE    = 2'd1;
  localparam logic [1:0] STAT_OUTSIDE = 2'd2;
  localparam logic [1:0] STAT_SAT     = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_HALF_VIEW    = 2'd0;
  localparam logic [1:0] CFG_VIEW_TO_GRID = 2'd1;
  localparam logic [1:0] CFG_EDGE_MARGIN  = 2'd2;

  // configuration widths and reset values
  localparam int HALF_VIEW_W    = 31;
  localparam int VIEW_TO_GRID_W = 24;
  localparam int EDGE_MARGIN_W  = 6;
  localparam int CFG_DATA_W     = 31;
  localparam logic [HALF_VIEW_W-1:0]    HALF_VIEW_RST    = 31'd8192000;
  localparam logic [VIEW_TO_GRID_W-1:0] VIEW_TO_GRID_RST = 24'd16777;
  localparam logic [EDGE_MARGIN_W-1:0]  EDGE_MARGIN_RST  = 6'd10;

  // field widths
  localparam int POS_W    = 32;
  localparam int CELL_W   = 32;
  localparam int DSQ_W    = 63;
  localparam int WEIGHT_W = 17;   // Q1.16 weight, center weight is 65536
  localparam int IDX_W    = 26;   // signed per-axis cell index

  // fixed density reported near the grid edge, Q31.32
  localparam logic [DSQ_W-1:0] EDGE_DSQ = DSQ_W'(64'd10000 << 32);

  // rounding offset of one half in Q16.16
  localparam logic [POS_W-1:0] HALF_Q16 = 32'd32768;

  typedef struct packed {
    logic [1:0]              func;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
  } in_item_t;

  typedef struct packed {
    logic [DSQ_W-1:0] density_sq;
    logic [1:0]       status;
  } out_item_t;

endpackage

// ===== hw/rtl/dgs_stream_if.sv =====
// valid/ready stream channel carrying one payload item per transaction
interface dgs_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/dgs_weight.sv =====
// tent kernel weight pipeline: (a_i*a_j*a_k*65536 + R^3/2) / R^3
module dgs_weight #(
  parameter int KERNEL_RADIUS = 10
) (
  input  logic                                 clk,
  input  logic [$clog2(KERNEL_RADIUS+1)-1:0]   a_i,
  input  logic [$clog2(KERNEL_RADIUS+1)-1:0]   a_j,
  input  logic [$clog2(KERNEL_RADIUS+1)-1:0]   a_k,
  output logic [dgs_pkg::WEIGHT_W-1:0]         weight
);

  localparam int AKW    = $clog2(KERNEL_RADIUS + 1);
  localparam int PW     = 3 * AKW;
  localparam int R3     = KERNEL_RADIUS * KERNEL_RADIUS * KERNEL_RADIUS;
  localparam int DW     = $clog2(R3 + 1);
  localparam int SH     = DW + 16;
  localparam int WW     = dgs_pkg::WEIGHT_W;
  localparam longint unsigned RECIP = (64'd1 << SH) / R3;
  localparam int RW     = SH + 1;

  logic [2*AKW-1:0]  p1;
  logic [AKW-1:0]    ak_d;
  logic [PW-1:0]     p;
  logic [SH-1:0]     num3;
  logic [WW-1:0]     qe3;
  logic [SH-1:0]     num4;
  logic [WW-1:0]     qe4;
  logic [SH:0]       qd4;
  logic [SH-1:0]     num_c;
  logic [SH+RW-1:0]  prod_c;
  logic [SH:0]       rem_c;

  // numerator and reciprocal product
  always_comb begin
    num_c  = SH'({p[DW-1:0], 16'd0}) + SH'(R3 / 2);
    prod_c = (SH+RW)'(num_c) * (SH+RW)'(RECIP);
    rem_c  = {1'b0, num4} - qd4;
  end

  // stages: tent product, full product, reciprocal estimate, back-multiply, correction
  always_ff @(posedge clk) begin
    p1     <= (2*AKW)'(a_i) * (2*AKW)'(a_j);
    ak_d   <= a_k;
    p      <= PW'(p1) * PW'(ak_d);
    num3   <= num_c;
    qe3    <= prod_c[SH +: WW];
    num4   <= num3;
    qe4    <= qe3;
    qd4    <= (SH+1)'(qe3) * (SH+1)'(R3);
    weight <= (rem_c >= (SH+1)'(R3)) ? qe4 + WW'(1) : qe4;
  end

endmodule

// ===== hw/rtl/density_grid_splat_3d.sv =====
// top level of the cubic density grid with tent kernel splatting
//
//  channel   dir  handshake          payload
//  items     in   valid/ready        func, pos_x, pos_y, pos_z
//  results   out  valid/ready        density_sq, status
//  cfg       in   cfg_we (no stall)  cfg_index, cfg_data
//
// an add or subtract updates the cube one cell per cycle through the
// read-modify-write path of the cell memory
// after reset a clearing pass writes GRID_SIDE^3 cells, one per cycle,
// before the first item is taken; config writes are taken at any time
// results sit in an output register, so a stalled result does not stop the next item
module density_grid_splat_3d #(
  parameter int GRID_SIDE     = 64,
  parameter int KERNEL_RADIUS = 10
) (
  input  logic                              clk,
  input  logic                              rst,
  dgs_stream_if.sink                        items,
  dgs_stream_if.source                      results,
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_index,
  input  logic [dgs_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int CELLS  = GRID_SIDE * GRID_SIDE * GRID_SIDE;
  localparam int AW     = $clog2(CELLS);
  localparam int GW     = $clog2(GRID_SIDE);
  localparam int KW     = $clog2(2 * KERNEL_RADIUS + 1);
  localparam int AKW    = $clog2(KERNEL_RADIUS + 1);
  localparam int CW     = dgs_pkg::IDX_W;
  localparam int WW     = dgs_pkg::WEIGHT_W;
  localparam int LAT    = 5;
  localparam int ROW_STEP   = GRID_SIDE - 2 * KERNEL_RADIUS;
  localparam int PLANE_STEP = GRID_SIDE * GRID_SIDE - 2 * KERNEL_RADIUS * GRID_SIDE
                              - 2 * KERNEL_RADIUS;
  localparam logic [KW-1:0] K_LAST = KW'(2 * KERNEL_RADIUS);
  localparam logic signed [CW-1:0] SPLAT_LO = CW'(KERNEL_RADIUS);
  localparam logic signed [CW-1:0] SPLAT_HI = CW'(GRID_SIDE - 1 - KERNEL_RADIUS);
  localparam logic signed [CW-1:0] GRID_LAST = CW'(GRID_SIDE - 1);
  localparam logic signed [CW-1:0] GRID_N    = CW'(GRID_SIDE);

  typedef enum logic [13:0] {
    S_CLEAR  = 14'b00000000000001,
    S_IDLE   = 14'b00000000000010,
    S_IDX_AD = 14'b00000000000100,
    S_IDX_MU = 14'b00000000001000,
    S_IDX_SV = 14'b00000000010000,
    S_DECIDE = 14'b00000000100000,
    S_ADDR1  = 14'b00000001000000,
    S_ADDR2  = 14'b00000010000000,
    S_SWEEP  = 14'b00000100000000,
    S_DRAIN  = 14'b00001000000000,
    S_Q_RD   = 14'b00010000000000,
    S_Q_ABS  = 14'b00100000000000,
    S_Q_SQR  = 14'b01000000000000,
    S_FINISH = 14'b10000000000000
  } state_t;

  state_t state_q, state_next;

  // configuration
  logic [dgs_pkg::HALF_VIEW_W-1:0]    view_offset_q;
  logic [dgs_pkg::VIEW_TO_GRID_W-1:0] vtg_q;
  logic [dgs_pkg::EDGE_MARGIN_W-1:0]  margin_q;

  // latched item and per-axis index
  logic [1:0]                     func_q;
  logic [dgs_pkg::POS_W-1:0]      pos_q [3];
  logic [1:0]                     ax_q;
  logic                           neg_q;
  logic [32:0]                    mag_q;
  logic [24:0]                    q_q;
  logic signed [CW-1:0]           c_q [3];
  logic [GW-1:0]                  lo_q [3];
  logic [AW-1:0]                  row_q;
  logic [AW-1:0]                  base_q;

  // sweep counters and cell pipeline
  logic [KW-1:0]                  i_q, j_q, k_q;
  logic [AW-1:0]                  addr_q;
  logic [LAT:1]                   v_q;
  logic [AW-1:0]                  addr_d [LAT];
  logic                           sat_q;
  logic [WW-1:0]                  weight;

  // cell memory
  logic [dgs_pkg::CELL_W-1:0]     mem [CELLS];
  logic [dgs_pkg::CELL_W-1:0]     rd_data;
  logic [AW-1:0]                  rd_addr;
  logic [AW-1:0]                  clr_addr_q;
  logic                           wr_en;
  logic [AW-1:0]                  wr_addr;
  logic [dgs_pkg::CELL_W-1:0]     wr_data;

  // query path and result
  logic [31:0]                    qmag_q;
  logic [dgs_pkg::DSQ_W-1:0]      res_dsq_q;
  logic [1:0]                     res_status_q;
  logic                           out_valid_q;
  dgs_pkg::out_item_t             out_q;

  // combinational helpers
  logic [33:0]                    sum_c;
  logic [56:0]                    prod_c;
  logic                           splat_ok_c;
  logic                           edge_c;
  logic                           last_c;
  logic signed [CW-1:0]           margin_s;
  logic signed [CW-1:0]           edge_hi_s;
  logic signed [dgs_pkg::CELL_W+1:0] cell_sum_c;
  logic                           clip_hi_c, clip_lo_c;
  logic [AKW-1:0]                 a_i, a_j, a_k;

  function automatic logic [AKW-1:0] tent_a(input logic [KW-1:0] n);
    logic [KW-1:0] t;
    t = (n <= KW'(KERNEL_RADIUS)) ? n : K_LAST - n;
    return t[AKW-1:0];
  endfunction

  // index arithmetic and range checks
  always_comb begin
    sum_c = {{2{pos_q[ax_q][31]}}, pos_q[ax_q]} + {3'd0, view_offset_q}
            + {2'd0, dgs_pkg::HALF_Q16};
    prod_c = 57'(mag_q) * 57'(vtg_q);
    margin_s = $signed(CW'(margin_q));
    edge_hi_s = GRID_N - margin_s;
    splat_ok_c = 1'b1;
    edge_c = 1'b0;
    for (int a = 0; a < 3; a++) begin
      if (c_q[a] < SPLAT_LO || c_q[a] > SPLAT_HI) begin
        splat_ok_c = 1'b0;
      end
      if (c_q[a] < margin_s || c_q[a] > edge_hi_s || c_q[a] < 0 || c_q[a] > GRID_LAST) begin
        edge_c = 1'b1;
      end
    end
    last_c = (i_q == K_LAST) && (j_q == K_LAST) && (k_q == K_LAST);
  end

  // kernel weights
  assign a_i = tent_a(i_q);
  assign a_j = tent_a(j_q);
  assign a_k = tent_a(k_q);

  dgs_weight #(
    .KERNEL_RADIUS(KERNEL_RADIUS)
  ) u_weight (
    .clk   (clk),
    .a_i   (a_i),
    .a_j   (a_j),
    .a_k   (a_k),
    .weight(weight)
  );

  // cell update with saturation
  always_comb begin
    if (func_q == dgs_pkg::FUNC_SUB) begin
      cell_sum_c = $signed({{2{rd_data[31]}}, rd_data}) - $signed({17'd0, weight});
    end else begin
      cell_sum_c = $signed({{2{rd_data[31]}}, rd_data}) + $signed({17'd0, weight});
    end
    clip_hi_c = !cell_sum_c[33] && (cell_sum_c[32:31] != 2'b00);
    clip_lo_c = cell_sum_c[33] && (cell_sum_c[32:31] != 2'b11);
  end

  // memory port selection
  always_comb begin
    rd_addr = (state_q == S_Q_RD) ? base_q : addr_d[LAT-2];
    if (state_q == S_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr_q;
      wr_data = '0;
    end else begin
      wr_en   = v_q[LAT];
      wr_addr = addr_d[LAT-1];
      if (clip_hi_c) begin
        wr_data = 32'h7fff_ffff;
      end else if (clip_lo_c) begin
        wr_data = 32'h8000_0000;
      end else begin
        wr_data = cell_sum_c[31:0];
      end
    end
  end

  // cell memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // sequencer
  always_comb begin
    state_next = state_q;
    case (state_q)
      S_CLEAR: begin
        if (clr_addr_q == AW'(CELLS - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (items.valid) state_next = S_IDX_AD;
      end
      S_IDX_AD: state_next = S_IDX_MU;
      S_IDX_MU: state_next = S_IDX_SV;
      S_IDX_SV: state_next = (ax_q == 2'd2) ? S_DECIDE : S_IDX_AD;
      S_DECIDE: begin
        if (func_q inside {dgs_pkg::FUNC_ADD, dgs_pkg::FUNC_SUB}) begin
          state_next = splat_ok_c ? S_ADDR1 : S_FINISH;
        end else if (func_q == dgs_pkg::FUNC_QUERY) begin
          state_next = edge_c ? S_FINISH : S_ADDR1;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_ADDR1: state_next = S_ADDR2;
      S_ADDR2: state_next = (func_q == dgs_pkg::FUNC_QUERY) ? S_Q_RD : S_SWEEP;
      S_SWEEP: begin
        if (last_c) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        if (v_q == '0) state_next = S_FINISH;
      end
      S_Q_RD:  state_next = S_Q_ABS;
      S_Q_ABS: state_next = S_Q_SQR;
      S_Q_SQR: state_next = S_FINISH;
      S_FINISH: begin
        if (!out_valid_q || results.ready) state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state_q       <= S_CLEAR;
      clr_addr_q    <= '0;
      v_q           <= '0;
      out_valid_q   <= 1'b0;
      view_offset_q <= dgs_pkg::HALF_VIEW_RST;
      vtg_q         <= dgs_pkg::VIEW_TO_GRID_RST;
      margin_q      <= dgs_pkg::EDGE_MARGIN_RST;
    end else begin
      state_q <= state_next;
      if (state_q == S_CLEAR) clr_addr_q <= clr_addr_q + AW'(1);
      v_q <= {v_q[LAT-1:1], state_q == S_SWEEP};
      // result register
      if (state_q == S_FINISH && (!out_valid_q || results.ready)) begin
        out_valid_q <= 1'b1;
      end else if (results.ready) begin
        out_valid_q <= 1'b0;
      end
      // configuration writes
      if (cfg_we) begin
        case (cfg_index)
          dgs_pkg::CFG_HALF_VIEW:    view_offset_q <= cfg_data;
          dgs_pkg::CFG_VIEW_TO_GRID: vtg_q <= cfg_data[dgs_pkg::VIEW_TO_GRID_W-1:0];
          dgs_pkg::CFG_EDGE_MARGIN:  margin_q <= cfg_data[dgs_pkg::EDGE_MARGIN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    // item capture
    if (state_q == S_IDLE && items.valid) begin
      func_q   <= items.data.func;
      pos_q[0] <= items.data.pos_x;
      pos_q[1] <= items.data.pos_y;
      pos_q[2] <= items.data.pos_z;
      ax_q     <= 2'd0;
    end
    // cell index per axis: add, scale, sign
    if (state_q == S_IDX_AD) begin
      neg_q <= sum_c[33];
      mag_q <= sum_c[33] ? 33'(~sum_c + 34'd1) : sum_c[32:0];
    end
    if (state_q == S_IDX_MU) q_q <= prod_c[56:32];
    if (state_q == S_IDX_SV) begin
      c_q[ax_q] <= neg_q ? -$signed({1'b0, q_q}) : $signed({1'b0, q_q});
      ax_q      <= ax_q + 2'd1;
    end
    // lower corner of the cube, or the cell itself for a query
    if (state_q == S_DECIDE) begin
      for (int a = 0; a < 3; a++) begin
        if (func_q == dgs_pkg::FUNC_QUERY) begin
          lo_q[a] <= c_q[a][GW-1:0];
        end else begin
          lo_q[a] <= GW'(c_q[a] - SPLAT_LO);
        end
      end
      if (func_q inside {dgs_pkg::FUNC_ADD, dgs_pkg::FUNC_SUB}) begin
        res_dsq_q    <= '0;
        res_status_q <= splat_ok_c ? dgs_pkg::STAT_OK : dgs_pkg::STAT_OUTSIDE;
      end else if (func_q == dgs_pkg::FUNC_QUERY) begin
        res_dsq_q    <= edge_c ? dgs_pkg::EDGE_DSQ : '0;
        res_status_q <= edge_c ? dgs_pkg::STAT_EDGE : dgs_pkg::STAT_OK;
      end else begin
        res_dsq_q    <= '0;
        res_status_q <= dgs_pkg::STAT_OK;
      end
    end
    // linear address in two constant multiplies
    if (state_q == S_ADDR1) row_q <= AW'(lo_q[2] * GRID_SIDE) + AW'(lo_q[1]);
    if (state_q == S_ADDR2) begin
      base_q <= AW'(row_q * GRID_SIDE) + AW'(lo_q[0]);
      addr_q <= AW'(row_q * GRID_SIDE) + AW'(lo_q[0]);
      i_q    <= '0;
      j_q    <= '0;
      k_q    <= '0;
      sat_q  <= 1'b0;
    end
    // cube sweep, x fastest
    if (state_q == S_SWEEP) begin
      if (i_q != K_LAST) begin
        i_q    <= i_q + KW'(1);
        addr_q <= addr_q + AW'(1);
      end else if (j_q != K_LAST) begin
        i_q    <= '0;
        j_q    <= j_q + KW'(1);
        addr_q <= addr_q + AW'(ROW_STEP);
      end else begin
        i_q    <= '0;
        j_q    <= '0;
        k_q    <= k_q + KW'(1);
        addr_q <= addr_q + AW'(PLANE_STEP);
      end
    end
    // address delay line matching the weight pipeline and the memory read
    addr_d[0] <= addr_q;
    for (int s = 1; s < LAT; s++) begin
      addr_d[s] <= addr_d[s-1];
    end
    if (v_q[LAT] && (clip_hi_c || clip_lo_c)) sat_q <= 1'b1;
    if (state_q == S_DRAIN && v_q == '0 && sat_q) res_status_q <= dgs_pkg::STAT_SAT;
    // query square
    if (state_q == S_Q_ABS) qmag_q <= rd_data[31] ? 32'(~rd_data + 32'd1) : rd_data;
    if (state_q == S_Q_SQR) res_dsq_q <= 63'(64'(qmag_q) * 64'(qmag_q));
    // output register
    if (state_q == S_FINISH && (!out_valid_q || results.ready)) begin
      out_q.density_sq <= res_dsq_q;
      out_q.status     <= res_status_q;
    end
  end

  assign items.ready   = (state_q == S_IDLE);
  assign results.valid = out_valid_q;
  assign results.data  = out_q;

endmodule

// ===== bench/density_grid_checker.sv =====
// watches the item, result and register ports of the density grid and checks every result
`timescale 1ns / 100ps

module density_grid_checker #(
  parameter int GRID_SIDE     = 64,
  parameter int KERNEL_RADIUS = 10
) (
  input  logic                           clk,
  input  logic                           rst,
  dgs_stream_if                          items,
  dgs_stream_if                          results,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_index,
  input  logic [dgs_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             fail_count,
  output int                             results_owed,
  output int                             items_seen,
  output int                             results_seen,
  output int                             status_count [4]
);

  localparam int POS_W          = dgs_pkg::POS_W;
  localparam int DSQ_W          = dgs_pkg::DSQ_W;
  localparam int HALF_VIEW_W    = dgs_pkg::HALF_VIEW_W;
  localparam int VIEW_TO_GRID_W = dgs_pkg::VIEW_TO_GRID_W;
  localparam int EDGE_MARGIN_W  = dgs_pkg::EDGE_MARGIN_W;

  // shadow copy of the grid and the registers
  int                         grid_cells [GRID_SIDE*GRID_SIDE*GRID_SIDE];
  logic [HALF_VIEW_W-1:0]     view_offset;
  logic [VIEW_TO_GRID_W-1:0]  grid_scale;
  logic [EDGE_MARGIN_W-1:0]   edge_margin;
  dgs_pkg::out_item_t         owed_results [$];

  // (coord + offset + one half) * scale, integer part toward zero
  function automatic longint axis_cell(logic signed [POS_W-1:0] coord);
    longint          sum;
    longint          whole;
    longint unsigned mag;
    sum   = longint'(coord) + longint'(view_offset) + longint'(dgs_pkg::HALF_Q16);
    mag   = (sum < 0) ? longint'(-sum) : longint'(sum);
    whole = longint'((mag * longint'(grid_scale)) >> 32);
    return (sum < 0) ? -whole : whole;
  endfunction

  function automatic bit near_edge(longint c);
    longint margin;
    margin = longint'(edge_margin);
    return (c < margin) || (c > GRID_SIDE - margin) || (c < 0) || (c > GRID_SIDE - 1);
  endfunction

  // add or remove the tent kernel on the whole cube, saturating each cell
  function automatic logic [1:0] splat_cube(longint cx, longint cy, longint cz, bit remove);
    longint r;
    longint r3;
    longint tent_prod;
    longint weight;
    longint sum;
    int     idx;
    bit     clipped;
    r       = KERNEL_RADIUS;
    r3      = r * r * r;
    clipped = 1'b0;
    if ((cx - r < 0) || (cx + r > GRID_SIDE - 1) || (cy - r < 0) || (cy + r > GRID_SIDE - 1) ||
        (cz - r < 0) || (cz + r > GRID_SIDE - 1)) begin
      return dgs_pkg::STAT_OUTSIDE;
    end
    for (int k = -KERNEL_RADIUS; k <= KERNEL_RADIUS; k++) begin
      for (int j = -KERNEL_RADIUS; j <= KERNEL_RADIUS; j++) begin
        for (int i = -KERNEL_RADIUS; i <= KERNEL_RADIUS; i++) begin
          tent_prod = (r - ((i < 0) ? -i : i)) * (r - ((j < 0) ? -j : j)) *
                      (r - ((k < 0) ? -k : k));
          weight    = (tent_prod * 65536 + r3 / 2) / r3;
          idx       = int'(((cz + k) * GRID_SIDE + (cy + j)) * GRID_SIDE + (cx + i));
          sum       = longint'(grid_cells[idx]) + (remove ? -weight : weight);
          if (sum > 64'sd2147483647) begin
            sum     = 64'sd2147483647;
            clipped = 1'b1;
          end
          if (sum < -64'sd2147483648) begin
            sum     = -64'sd2147483648;
            clipped = 1'b1;
          end
          grid_cells[idx] = int'(sum);
        end
      end
    end
    return clipped ? dgs_pkg::STAT_SAT : dgs_pkg::STAT_OK;
  endfunction

  // expected result of one item, updating the shadow grid
  function automatic dgs_pkg::out_item_t density_result(dgs_pkg::in_item_t it);
    dgs_pkg::out_item_t res;
    longint             cx;
    longint             cy;
    longint             cz;
    longint             cell_val;
    longint             mag;
    res = '0;
    cx  = axis_cell(it.pos_x);
    cy  = axis_cell(it.pos_y);
    cz  = axis_cell(it.pos_z);
    case (it.func)
      dgs_pkg::FUNC_ADD, dgs_pkg::FUNC_SUB: begin
        res.status = splat_cube(cx, cy, cz, it.func == dgs_pkg::FUNC_SUB);
      end
      dgs_pkg::FUNC_QUERY: begin
        if (near_edge(cx) || near_edge(cy) || near_edge(cz)) begin
          res.density_sq = dgs_pkg::EDGE_DSQ;
          res.status     = dgs_pkg::STAT_EDGE;
        end else begin
          cell_val       = longint'(grid_cells[int'((cz * GRID_SIDE + cy) * GRID_SIDE + cx)]);
          mag            = (cell_val < 0) ? -cell_val : cell_val;
          res.density_sq = DSQ_W'(mag * mag);
          res.status     = dgs_pkg::STAT_OK;
        end
      end
      default: begin
        // unused operation leaves everything alone
      end
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string what, dgs_pkg::out_item_t got,
                                 dgs_pkg::out_item_t want);
    $display("%0t mismatch, %s: got dsq %h status %0d, expected dsq %h status %0d",
             $time, what, got.density_sq, got.status, want.density_sq, want.status);
    fail_count++;
  endtask

  // sample every port at the edge: registers, results, then new items
  always @(posedge clk) begin : watch
    dgs_pkg::out_item_t got;
    dgs_pkg::out_item_t want;
    if (rst) begin
      view_offset  = dgs_pkg::HALF_VIEW_RST;
      grid_scale   = dgs_pkg::VIEW_TO_GRID_RST;
      edge_margin  = dgs_pkg::EDGE_MARGIN_RST;
      owed_results.delete();
      fail_count   = 0;
      items_seen   = 0;
      results_seen = 0;
      foreach (status_count[s]) status_count[s] = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          dgs_pkg::CFG_HALF_VIEW:    view_offset = cfg_data[HALF_VIEW_W-1:0];
          dgs_pkg::CFG_VIEW_TO_GRID: grid_scale  = cfg_data[VIEW_TO_GRID_W-1:0];
          dgs_pkg::CFG_EDGE_MARGIN:  edge_margin = cfg_data[EDGE_MARGIN_W-1:0];
          default: begin
          end
        endcase
      end
      // a result always belongs to an item taken at an earlier edge
      if (results.valid && results.ready) begin
        got = results.data;
        results_seen++;
        status_count[got.status]++;
        if (owed_results.size() == 0) begin
          report_mismatch("result with nothing outstanding", got, '0);
        end else begin
          want = owed_results[0];
          owed_results.delete(0);
          if (got.density_sq !== want.density_sq) report_mismatch("density_sq", got, want);
          if (got.status !== want.status) report_mismatch("status", got, want);
        end
      end
      if (items.valid && items.ready) begin
        items_seen++;
        owed_results.insert(owed_results.size(), density_result(items.data));
      end
    end
    results_owed = owed_results.size();
  end

endmodule

// ===== bench/tb_density_grid_splat_3d.sv =====
// stimulus, idling, watchdog and verdict for the density grid splat block
`timescale 1ns / 100ps

module tb_density_grid_splat_3d;

  localparam int GRID_SIDE      = 64;
  localparam int KERNEL_RADIUS  = 10;
  localparam int SPLAT_CYCLES   = (2*KERNEL_RADIUS+1)**3 + 19;
  localparam int CLEAR_CYCLES   = GRID_SIDE**3;
  localparam int WATCHDOG_LIMIT = 3 * (CLEAR_CYCLES + SPLAT_CYCLES + 256);

  localparam int POS_W          = dgs_pkg::POS_W;
  localparam int CFG_DATA_W     = dgs_pkg::CFG_DATA_W;
  localparam int HALF_VIEW_W    = dgs_pkg::HALF_VIEW_W;
  localparam int VIEW_TO_GRID_W = dgs_pkg::VIEW_TO_GRID_W;
  localparam int EDGE_MARGIN_W  = dgs_pkg::EDGE_MARGIN_W;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam logic [1:0] CFG_UNUSED  = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [1:0]            cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int fail_count;
  int results_owed;
  int items_seen;
  int results_seen;
  int status_count [4];
  int idle_cycles = 0;
  int burst_left  = 0;

  logic signed [POS_W-1:0] last_x = '0;
  logic signed [POS_W-1:0] last_y = '0;
  logic signed [POS_W-1:0] last_z = '0;

  dgs_stream_if #(.T(dgs_pkg::in_item_t))  items_ch ();
  dgs_stream_if #(.T(dgs_pkg::out_item_t)) results_ch ();

  density_grid_splat_3d #(
    .GRID_SIDE     (GRID_SIDE),
    .KERNEL_RADIUS (KERNEL_RADIUS)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .items     (items_ch),
    .results   (results_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  density_grid_checker #(
    .GRID_SIDE     (GRID_SIDE),
    .KERNEL_RADIUS (KERNEL_RADIUS)
  ) u_grid_check (
    .clk          (clk),
    .rst          (rst),
    .items        (items_ch),
    .results      (results_ch),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .results_owed (results_owed),
    .items_seen   (items_seen),
    .results_seen (results_seen),
    .status_count (status_count)
  );

  always #5 clk = ~clk;

  // result side: runs of always ready, coin flips and long stalls
  initial begin : result_stall
    int mode;
    int span;
    results_ch.ready <= 1'b0;
    forever begin
      mode = $urandom_range(0, 2);
      span = $urandom_range(8, 120);
      repeat (span) begin
        @(posedge clk);
        case (mode)
          0:       results_ch.ready <= 1'b1;
          1:       results_ch.ready <= 1'($urandom_range(0, 1));
          default: results_ch.ready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if ((items_ch.valid && items_ch.ready) || (results_ch.valid && results_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired after %0d idle cycles", idle_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic signed [POS_W-1:0] q16(int units);
    return POS_W'(units * 65536);
  endfunction

  function automatic dgs_pkg::in_item_t make_item(logic [1:0] op,
                                                  logic signed [POS_W-1:0] x,
                                                  logic signed [POS_W-1:0] y,
                                                  logic signed [POS_W-1:0] z);
    dgs_pkg::in_item_t it;
    it.func  = op;
    it.pos_x = x;
    it.pos_y = y;
    it.pos_z = z;
    return it;
  endfunction

  // mostly inside the given span of view units, now and then any 32-bit value
  function automatic logic signed [POS_W-1:0] rand_coord(int lo_u, int hi_u);
    longint span;
    span = longint'(hi_u - lo_u) * 65536;
    if ($urandom_range(0, 9) == 0) return $urandom;
    return POS_W'(longint'(lo_u) * 65536 + longint'($urandom_range(0, 32'(span))));
  endfunction

  // within four view units of a point
  function automatic logic signed [POS_W-1:0] near(logic signed [POS_W-1:0] p);
    return p + POS_W'(int'($urandom_range(0, 524288)) - 262144);
  endfunction

  // one item transaction; bursts of random length with random gaps between them
  task automatic send(dgs_pkg::in_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if ($urandom_range(0, 15) == 0) gap = $urandom_range(20, 60);
      if (gap > 0) begin
        items_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 10);
    end
    items_ch.valid <= 1'b1;
    items_ch.data  <= it;
    do @(posedge clk); while (!items_ch.ready);
    burst_left--;
  endtask

  // stop sending and let every outstanding result come back
  task automatic wait_drained();
    items_ch.valid <= 1'b0;
    do @(negedge clk); while (results_owed != 0);
    @(posedge clk);
    burst_left = 0;
  endtask

  task automatic apply_config(logic [HALF_VIEW_W-1:0] hv, logic [VIEW_TO_GRID_W-1:0] scale,
                              logic [EDGE_MARGIN_W-1:0] margin);
    cfg_we    <= 1'b1;
    cfg_index <= dgs_pkg::CFG_HALF_VIEW;
    cfg_data  <= CFG_DATA_W'(hv);
    @(posedge clk);
    cfg_index <= dgs_pkg::CFG_VIEW_TO_GRID;
    cfg_data  <= CFG_DATA_W'(scale);
    @(posedge clk);
    cfg_index <= dgs_pkg::CFG_EDGE_MARGIN;
    cfg_data  <= CFG_DATA_W'(margin);
    @(posedge clk);
    // unused index must be ignored
    cfg_index <= CFG_UNUSED;
    cfg_data  <= '1;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // random splats and unused ops, removals often of the last splat, queries often by it
  task automatic run_random(int count, int lo_u, int hi_u);
    int                      pick;
    logic [1:0]              op;
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    logic signed [POS_W-1:0] pz;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      px   = rand_coord(lo_u, hi_u);
      py   = rand_coord(lo_u, hi_u);
      pz   = rand_coord(lo_u, hi_u);
      if (pick < 30)      op = dgs_pkg::FUNC_ADD;
      else if (pick < 45) op = dgs_pkg::FUNC_SUB;
      else if (pick < 92) op = dgs_pkg::FUNC_QUERY;
      else                op = FUNC_UNUSED;
      if ((op == dgs_pkg::FUNC_SUB) && ($urandom_range(0, 1) == 1)) begin
        px = last_x;
        py = last_y;
        pz = last_z;
      end else if ((op == dgs_pkg::FUNC_QUERY) && ($urandom_range(0, 1) == 1)) begin
        px = near(last_x);
        py = near(last_y);
        pz = near(last_z);
      end
      if (op == dgs_pkg::FUNC_ADD) begin
        last_x = px;
        last_y = py;
        last_z = pz;
      end
      send(make_item(op, px, py, pz));
    end
  endtask

  initial begin : stimulus
    rst            <= 1'b1;
    items_ch.valid <= 1'b0;
    items_ch.data  <= '0;
    cfg_we         <= 1'b0;
    cfg_index      <= dgs_pkg::CFG_HALF_VIEW;
    cfg_data       <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset settings: x = 0 lands on cell 32, cells 10 and 53 are the last whole cubes
    send(make_item(dgs_pkg::FUNC_QUERY, q16(0), q16(0), q16(0)));
    send(make_item(dgs_pkg::FUNC_ADD, q16(0), q16(0), q16(0)));
    send(make_item(dgs_pkg::FUNC_QUERY, q16(0), q16(0), q16(0)));
    send(make_item(dgs_pkg::FUNC_ADD, q16(8), q16(0), q16(0)));
    send(make_item(dgs_pkg::FUNC_QUERY, q16(0), q16(0), q16(0)));
    send(make_item(dgs_pkg::FUNC_SUB, q16(0), q16(0), q16(0)));
    send(make_item(dgs_pkg::FUNC_QUERY, q16(0), q16(0), q16(0)));
    send(make_item(dgs_pkg::FUNC_QUERY, q16(8), q16(0), q16(0)));
    // cube touching the low and high faces, and one cell past each
    send(make_item(dgs_pkg::FUNC_ADD, q16(-84), q16(-84), q16(-84)));
    send(make_item(dgs_pkg::FUNC_ADD, q16(-88), q16(0), q16(0)));
    send(make_item(dgs_pkg::FUNC_ADD, q16(83), q16(83), q16(83)));
    send(make_item(dgs_pkg::FUNC_SUB, q16(0), q16(0), q16(87)));
    // query on both sides of the edge margin
    send(make_item(dgs_pkg::FUNC_QUERY, q16(-88), q16(0), q16(0)));
    send(make_item(dgs_pkg::FUNC_QUERY, q16(-84), q16(-84), q16(-84)));
    send(make_item(dgs_pkg::FUNC_QUERY, q16(87), q16(0), q16(0)));
    send(make_item(dgs_pkg::FUNC_QUERY, q16(0), q16(91), q16(0)));
    send(make_item(dgs_pkg::FUNC_QUERY, q16(83), q16(83), q16(83)));
    // coordinate extremes
    send(make_item(dgs_pkg::FUNC_ADD, 32'h7FFF_FFFF, q16(0), q16(0)));
    send(make_item(dgs_pkg::FUNC_QUERY, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send(make_item(dgs_pkg::FUNC_SUB, 32'h8000_0000, q16(0), q16(0)));
    send(make_item(dgs_pkg::FUNC_QUERY, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    // small negative sum truncates to cell zero
    send(make_item(dgs_pkg::FUNC_QUERY,
                   -(POS_W'(dgs_pkg::HALF_VIEW_RST) + dgs_pkg::HALF_Q16 + 1),
                   q16(0), q16(0)));
    // unused operation
    send(make_item(FUNC_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send(make_item(FUNC_UNUSED, q16(0), q16(0), q16(0)));
    run_random(15, -90, 86);
    wait_drained();

    // one view unit per cell, no margin
    apply_config('0, VIEW_TO_GRID_W'(65536), '0);
    run_random(30, 8, 57);
    wait_drained();

    // offset and scale at their top values, margin 32
    apply_config('1, '1, EDGE_MARGIN_W'(32));
    run_random(10, -32000, 32000);
    wait_drained();

    // zero scale maps every point to cell zero
    apply_config('0, '0, '0);
    run_random(10, -32000, 32000);
    wait_drained();

    // half scale with a margin of 32
    apply_config(HALF_VIEW_W'(4194304), VIEW_TO_GRID_W'(32768), EDGE_MARGIN_W'(32));
    run_random(15, -46, 44);
    wait_drained();

    // quiet period to catch any stray result
    repeat (SPLAT_CYCLES) @(posedge clk);

    $display("covered %0d item and %0d result transactions over five register settings",
             items_seen, results_seen);
    $display("results by status: ok %0d, edge %0d, outside %0d, saturated %0d",
             status_count[dgs_pkg::STAT_OK], status_count[dgs_pkg::STAT_EDGE],
             status_count[dgs_pkg::STAT_OUTSIDE], status_count[dgs_pkg::STAT_SAT]);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/dgs_pkg.sv
hw/rtl/dgs_stream_if.sv
hw/rtl/dgs_weight.sv
hw/rtl/density_grid_splat_3d.sv
bench/density_grid_checker.sv
bench/tb_density_grid_splat_3d.sv
